// ----- rtl/fmk3_pkg.sv -----
// Shared types and constants for the float-to-Morton-key block.
package fmk3_pkg;

  localparam int FRACTION_BITS = 20;
  localparam int COORD_BITS    = 21;
  localparam int FLOAT_BITS    = 32;
  localparam int KEY_BITS      = 63;
  localparam int LANES         = 3;

  // Exponent bias plus mantissa length of a single-precision value.
  localparam int EXP_OFFSET    = 150;
  localparam int MANT_BITS     = 24;
  localparam logic [7:0] EXP_SPECIAL = 8'hFF;
  localparam logic [7:0] EXP_ZERO    = 8'h00;

  typedef struct packed {
    logic [FLOAT_BITS-1:0] x_coord;
    logic [FLOAT_BITS-1:0] y_coord;
    logic [FLOAT_BITS-1:0] z_coord;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] morton_key;
    logic                range_error;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] coord;
    logic                  bad;
  } lane_res_t;

endpackage

// ----- rtl/float_to_morton_key_3d_top.sv -----
// Top level of the float-to-Morton-key block: three conversion lanes and a merge stage.
//
//  Channel | Ports                         | Direction | Carries
//  --------+-------------------------------+-----------+------------------------------
//  input   | in_valid, in_stall, in_item   | in        | x, y, z as single-precision
//  output  | out_valid, out_stall, out_item| out       | 63-bit key and error flag
//
// Each item passes through the lane registers, where three identical lanes
// scale and truncate x, y and z in parallel, and then through the output
// register, after the merge stage interleaves the bits.
// A new item is accepted every cycle while the output is taken.
// While the output is stalled, one further item is accepted into the lane
// registers; in_stall rises only when both stages hold an item.
// Reset is synchronous and active low and clears only the valid flags.
module float_to_morton_key_3d_top
  import fmk3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  logic      s2_load;
  logic      s1_free;
  logic      in_accept;
  lane_res_t x_res;
  lane_res_t y_res;
  lane_res_t z_res;

  // The lane stage drains into the output register unless that register
  // holds an item that is still stalled.
  assign s2_load   = s1_valid_r && !(out_valid && out_stall);
  assign s1_free   = !s1_valid_r || s2_load;
  assign in_stall  = !s1_free;
  assign in_accept = in_valid && s1_free;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s2_load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // One lane per coordinate; all three see the same load enable.
  fmk3_lane u_lane_x (
    .clk        (clk),
    .en         (in_accept),
    .coord_bits (in_item.x_coord),
    .res_r      (x_res)
  );

  fmk3_lane u_lane_y (
    .clk        (clk),
    .en         (in_accept),
    .coord_bits (in_item.y_coord),
    .res_r      (y_res)
  );

  fmk3_lane u_lane_z (
    .clk        (clk),
    .en         (in_accept),
    .coord_bits (in_item.z_coord),
    .res_r      (z_res)
  );

  fmk3_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (s2_load),
    .x_res       (x_res),
    .y_res       (y_res),
    .z_res       (z_res),
    .out_stall   (out_stall),
    .out_valid_r (out_valid),
    .out_item_r  (out_item)
  );

  // The input side only stalls when the lane stage holds an item.
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty lane stage");

  // A flagged item never carries a nonzero key.
  a_error_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_item.range_error && (out_item.morton_key != '0)))
    else $error("range error with nonzero key");

  // An item blocked behind a stalled output stays in the lane stage.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid && out_stall) |=> s1_valid_r)
    else $error("lane stage item lost under output stall");

  // An item moved out of the lane stage shows up at the output.
  a_s2_load: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |=> out_valid)
    else $error("item moved to output but output not valid");

endmodule

// ----- rtl/fmk3_lane.sv -----
// One conversion lane: single-precision value to a scaled, truncated integer.
module fmk3_lane
  import fmk3_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [FLOAT_BITS-1:0] coord_bits,
  output lane_res_t             res_r
);

  logic                 sign_c;
  logic [7:0]           expo_c;
  logic [MANT_BITS-1:0] mant_c;
  logic [9:0]           shift_c;
  logic [9:0]           shamt_c;
  logic [MANT_BITS-1:0] val_c;
  logic                 bad_c;
  lane_res_t            res_nxt;

  always_comb begin
    sign_c  = coord_bits[FLOAT_BITS-1];
    expo_c  = coord_bits[30:23];
    mant_c  = {1'b1, coord_bits[22:0]};
    // Signed shift: positive means a left shift of the mantissa.
    shift_c = 10'({2'b00, expo_c}) + 10'(FRACTION_BITS) - 10'(EXP_OFFSET);
    shamt_c = 10'd0 - shift_c;
    val_c   = '0;
    bad_c   = 1'b0;
    if (expo_c == EXP_SPECIAL) begin
      bad_c = 1'b1;
    end else if (expo_c != EXP_ZERO) begin
      if (!shift_c[9]) begin
        // The value is at least 2^(MANT_BITS-1), beyond any coordinate range.
        bad_c = 1'b1;
      end else if (shamt_c < 10'(MANT_BITS)) begin
        val_c = mant_c >> shamt_c[4:0];
      end
    end
    if (sign_c && (val_c != '0)) begin
      bad_c = 1'b1;
    end
    if ((val_c >> COORD_BITS) != '0) begin
      bad_c = 1'b1;
    end
    res_nxt.coord = val_c[COORD_BITS-1:0];
    res_nxt.bad   = bad_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- rtl/fmk3_merge.sv -----
// Merge stage: interleaves the three lane results into the key and holds the output item.
module fmk3_merge
  import fmk3_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  lane_res_t x_res,
  input  lane_res_t y_res,
  input  lane_res_t z_res,
  input  logic      out_stall,
  output logic      out_valid_r,
  output out_item_t out_item_r
);

  logic [KEY_BITS-1:0] key_c;
  logic                bad_c;
  out_item_t           out_item_nxt;
  logic                out_valid_nxt;

  always_comb begin
    key_c = '0;
    for (int k = 0; k < COORD_BITS; k++) begin
      key_c[3*k]     = x_res.coord[k];
      key_c[3*k + 1] = y_res.coord[k];
      key_c[3*k + 2] = z_res.coord[k];
    end
    bad_c = x_res.bad | y_res.bad | z_res.bad;
    out_item_nxt.morton_key  = bad_c ? '0 : key_c;
    out_item_nxt.range_error = bad_c;
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
